>>> hdl/slswc_pkg.sv
package slswc_pkg;

  localparam logic [2:0] STATUS_OK     = 3'd0;
  localparam logic [2:0] STATUS_CRC    = 3'd1;
  localparam logic [2:0] STATUS_SYSTEM = 3'd2;
  localparam logic [2:0] STATUS_IFACE  = 3'd3;
  localparam logic [2:0] STATUS_ANGLE  = 3'd4;

  localparam logic [7:0]  CRC_POLY  = 8'h1D;
  localparam logic [7:0]  CRC_SEED  = 8'hFF;
  localparam logic [5:0]  ANGLE_REG = 6'd2;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // Active-low flag positions in the guard word
  localparam int FLAG_SYSTEM_BIT = 14;
  localparam int FLAG_IFACE_BIT  = 13;
  localparam int FLAG_ANGLE_BIT  = 12;

  typedef struct packed {
    logic [5:0]  reg_address;
    logic        is_read;
    logic        safety_enabled;
    logic [15:0] data_word;
    logic [15:0] guard_word;
  } in_item_t;

  typedef struct packed {
    logic [14:0] held_angle;
    logic [15:0] failure_count;
    logic [2:0]  recent_failure;
  } track_state_t;

  typedef struct packed {
    logic [15:0]  command_out;
    logic [2:0]   status_code;
    track_state_t state;
  } out_item_t;

  // One byte of CRC-8, MSB first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] crc;
    crc = crc_in ^ data;
    for (int b = 0; b < 8; b++) begin
      if (crc[7]) begin
        crc = {crc[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[6:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

>>> hdl/slswc_if.sv
interface slswc_in_if;
  logic        valid;
  logic        ready;
  logic [5:0]  reg_address;
  logic        is_read;
  logic        safety_enabled;
  logic [15:0] data_word;
  logic [15:0] guard_word;

  modport source (output valid, reg_address, is_read, safety_enabled, data_word, guard_word,
                  input ready);
  modport sink (input valid, reg_address, is_read, safety_enabled, data_word, guard_word,
                output ready);
endinterface

interface slswc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] command_out;
  logic [2:0]  status_code;
  logic [14:0] angle_now;
  logic [15:0] error_total;
  logic [2:0]  last_failure;

  modport source (output valid, command_out, status_code, angle_now, error_total,
                  last_failure, input ready);
  modport sink (input valid, command_out, status_code, angle_now, error_total,
                last_failure, output ready);
endinterface

>>> hdl/slswc_check.sv
module slswc_check (
  input  slswc_pkg::in_item_t item,
  output logic [15:0]         command_out,
  output logic [2:0]          status_code
);
  import slswc_pkg::*;

  logic [7:0] crc;

  assign command_out = {item.is_read, 5'd0, item.reg_address, 3'd0, item.safety_enabled};

  always_comb begin
    crc = CRC_SEED;
    crc = crc8_byte(crc, command_out[15:8]);
    crc = crc8_byte(crc, command_out[7:0]);
    crc = crc8_byte(crc, item.data_word[15:8]);
    crc = crc8_byte(crc, item.data_word[7:0]);
    crc = ~crc;
  end

  // With safety disabled the status is OK; otherwise flags first in priority order, then the CRC
  always_comb begin
    if (!item.safety_enabled) begin
      status_code = STATUS_OK;
    end else if (!item.guard_word[FLAG_SYSTEM_BIT]) begin
      status_code = STATUS_SYSTEM;
    end else if (!item.guard_word[FLAG_IFACE_BIT]) begin
      status_code = STATUS_IFACE;
    end else if (!item.guard_word[FLAG_ANGLE_BIT]) begin
      status_code = STATUS_ANGLE;
    end else if (crc != item.guard_word[7:0]) begin
      status_code = STATUS_CRC;
    end else begin
      status_code = STATUS_OK;
    end
  end

endmodule

>>> hdl/slswc_track.sv
module slswc_track (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    upd,
  input  logic [2:0]              status_code,
  input  slswc_pkg::in_item_t     item,
  output slswc_pkg::track_state_t state_nxt
);
  import slswc_pkg::*;

  track_state_t state_r;

  always_comb begin
    state_nxt = state_r;
    if (upd) begin
      if (status_code == STATUS_OK) begin
        if (item.is_read && item.reg_address == ANGLE_REG) begin
          state_nxt.held_angle = item.data_word[14:0];
        end
      end else begin
        state_nxt.recent_failure = status_code;
        if (state_r.failure_count != COUNT_MAX) begin
          state_nxt.failure_count = state_r.failure_count + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> state_r.failure_count >= $past(state_r.failure_count))
    else $error("failure count went down");

  a_failure_pairs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.failure_count == 16'd0) == (state_r.recent_failure == STATUS_OK))
    else $error("failure count and last failure disagree");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !upd |=> $stable(state_r))
    else $error("state changed without an item");

endmodule

>>> hdl/sensor_link_safety_word_checker_top.sv
// Channel   Dir  Handshake           Payload
// in_beat   in   valid/ready         reg_address, is_read, safety_enabled, data_word, guard_word
// out_beat  out  valid/ready         command_out, status_code, angle_now, error_total, last_failure
//
// One beat in, one beat out; a new beat is taken every cycle while the output drains.
// Each beat passes the input register, then check and state update into the output register.
// The CRC over command and data bytes is a flat XOR network between those two registers.
// Synchronous active-low reset clears the held angle, failure count and last failure.
// A stalled output holds its beat; the input register fills and then in_beat.ready drops.
module sensor_link_safety_word_checker_top (
  input  logic        clk,
  input  logic        rst_n,
  slswc_in_if.sink    in_beat,
  slswc_out_if.source out_beat
);
  import slswc_pkg::*;

  logic         s1_valid_r;
  in_item_t     s1_item_r;
  logic         out_valid_r;
  out_item_t    out_item_r;
  logic         s1_adv;
  logic [15:0]  command;
  logic [2:0]   status;
  track_state_t state_nxt;

  assign s1_adv        = s1_valid_r && (!out_valid_r || out_beat.ready);
  assign in_beat.ready = !s1_valid_r || s1_adv;

  slswc_check u_check (
    .item        (s1_item_r),
    .command_out (command),
    .status_code (status)
  );

  slswc_track u_track (
    .clk         (clk),
    .rst_n       (rst_n),
    .upd         (s1_adv),
    .status_code (status),
    .item        (s1_item_r),
    .state_nxt   (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_beat.ready) begin
        s1_valid_r <= in_beat.valid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_beat.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat.ready && in_beat.valid) begin
      s1_item_r.reg_address    <= in_beat.reg_address;
      s1_item_r.is_read        <= in_beat.is_read;
      s1_item_r.safety_enabled <= in_beat.safety_enabled;
      s1_item_r.data_word      <= in_beat.data_word;
      s1_item_r.guard_word     <= in_beat.guard_word;
    end
    // capture the check result with the state it leaves
    if (s1_adv) begin
      out_item_r.command_out <= command;
      out_item_r.status_code <= status;
      out_item_r.state       <= state_nxt;
    end
  end

  assign out_beat.valid        = out_valid_r;
  assign out_beat.command_out  = out_item_r.command_out;
  assign out_beat.status_code  = out_item_r.status_code;
  assign out_beat.angle_now    = out_item_r.state.held_angle;
  assign out_beat.error_total  = out_item_r.state.failure_count;
  assign out_beat.last_failure = out_item_r.state.recent_failure;

endmodule
